FILE: hw/rtl/teq_pkg.sv
package teq_pkg;

  typedef enum logic [1:0] {
    KIND_FRONT  = 2'd0,
    KIND_MIDDLE = 2'd1,
    KIND_BACK   = 2'd2,
    KIND_GET    = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_DONE
  } state_t;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned POS_W  = 10;

endpackage

FILE: hw/rtl/teq_ring.sv
// One half of the queue: a circular buffer in a synchronous memory, with
// a head pointer and a fill count. Reads are registered.
module teq_ring #(
  parameter int unsigned DEPTH = 512
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       ins_head,
  input  logic                       ins_tail,
  input  logic                       drop_head,
  input  logic                       drop_tail,
  input  logic [teq_pkg::WORD_W-1:0] wdata,
  input  logic                       rd_en,
  input  logic [$clog2(DEPTH+1)-1:0] rd_off,
  output logic [teq_pkg::WORD_W-1:0] rdata,
  output logic [$clog2(DEPTH+1)-1:0] count
);
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [teq_pkg::WORD_W-1:0] mem [DEPTH];
  logic [AW-1:0] head;
  logic [AW-1:0] head_next;
  logic [CW-1:0] count_next;

  function automatic logic [AW-1:0] wrap(input logic [AW:0] a);
    logic [AW:0] d;
    d = (AW+1)'(DEPTH);
    return (a >= d) ? AW'(a - d) : a[AW-1:0];
  endfunction

  logic [AW-1:0] waddr;
  logic          wen;
  logic          grow;
  logic          shrink;

  // An insert at one end may coincide with a removal at the other; the
  // count then stays as it is.
  always_comb begin
    head_next  = head;
    count_next = count;
    wen        = 1'b0;
    waddr      = head;
    grow       = ins_head || ins_tail;
    shrink     = drop_head || drop_tail;
    if (ins_head) begin
      head_next = wrap({1'b0, head} + (AW+1)'(DEPTH - 1));
      waddr     = head_next;
      wen       = 1'b1;
    end else if (ins_tail) begin
      waddr = wrap({1'b0, head} + (AW+1)'(count));
      wen   = 1'b1;
    end
    if (drop_head) begin
      head_next = wrap({1'b0, head} + (AW+1)'(1));
    end
    if (grow && !shrink) begin
      count_next = count + 1'b1;
    end else if (shrink && !grow) begin
      count_next = count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      count <= '0;
    end else begin
      head  <= head_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (wen) begin
      mem[waddr] <= wdata;
    end
    if (rd_en) begin
      rdata <= mem[wrap({1'b0, head} + (AW+1)'(rd_off))];
    end
  end
endmodule

FILE: hw/rtl/teq_ctrl.sv
// Sequencer: decodes a request, reads any element that must move between
// the halves or that a get asks for, then applies the update and presents the result.
module teq_ctrl #(
  parameter int unsigned CAPACITY = 1024,
  parameter int unsigned HALF     = 512
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [1:0]                   kind,
  input  logic [teq_pkg::WORD_W-1:0]   value,
  input  logic [teq_pkg::POS_W-1:0]    position,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [teq_pkg::WORD_W-1:0]   read_value,
  output logic [1:0]                   status,
  output logic                         f_ins_head, f_ins_tail, f_drop_tail,
  output logic                         b_ins_head, b_ins_tail, b_drop_head,
  output logic [teq_pkg::WORD_W-1:0]   f_wdata, b_wdata,
  output logic                         f_rd_en, b_rd_en,
  output logic [$clog2(HALF+1)-1:0]    f_rd_off, b_rd_off,
  input  logic [teq_pkg::WORD_W-1:0]   f_rdata, b_rdata,
  input  logic [$clog2(HALF+1)-1:0]    f_count, b_count
);
  localparam int unsigned HW = $clog2(HALF + 1);
  localparam int unsigned TW = $clog2(CAPACITY + 1);
  localparam int unsigned XW = (TW > teq_pkg::POS_W) ? TW : teq_pkg::POS_W;

  teq_pkg::state_t state, state_next;

  logic [1:0]                 op;
  logic [teq_pkg::WORD_W-1:0] val;
  logic [teq_pkg::POS_W-1:0]  pos;

  logic [XW-1:0] total;
  logic [XW-1:0] pos_ext;
  logic          full;
  logic          in_front;
  logic          accept;

  // Invariant kept: front count equals back count or exceeds it by one.
  assign total    = XW'(f_count) + XW'(b_count);
  assign full     = total >= XW'(CAPACITY);
  assign pos_ext  = XW'(pos);
  assign in_front = pos_ext < XW'(f_count);
  assign accept   = in_valid && in_ready;
  assign in_ready = (state == teq_pkg::S_IDLE);

  always_comb begin
    state_next = state;
    unique case (state)
      teq_pkg::S_IDLE: if (in_valid) state_next = teq_pkg::S_EXEC;
      teq_pkg::S_EXEC: state_next = teq_pkg::S_DONE;
      teq_pkg::S_DONE: if (out_ready) state_next = teq_pkg::S_IDLE;
      default: state_next = teq_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= teq_pkg::S_IDLE;
    else     state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op  <= kind;
      val <= value;
      pos <= position;
    end
  end

  // Read in the idle cycle of acceptance: rebalance source, or get target.
  logic [XW-1:0] g_total;
  logic          g_front;
  always_comb begin
    g_total  = XW'(f_count) + XW'(b_count);
    g_front  = XW'(position) < XW'(f_count);
    f_rd_en  = 1'b0;
    b_rd_en  = 1'b0;
    f_rd_off = HW'(f_count - 1'b1);
    b_rd_off = '0;
    if (accept) begin
      unique case (teq_pkg::kind_t'(kind))
        teq_pkg::KIND_GET: begin
          if (g_front) begin
            f_rd_en  = 1'b1;
            f_rd_off = HW'(position);
          end else begin
            b_rd_en  = 1'b1;
            b_rd_off = HW'(XW'(position) - XW'(f_count));
          end
        end
        teq_pkg::KIND_FRONT: f_rd_en = (f_count != b_count);
        teq_pkg::KIND_MIDDLE: f_rd_en = 1'b0;
        teq_pkg::KIND_BACK: b_rd_en = (f_count == b_count) && (b_count != '0);
        default: ;
      endcase
      if (g_total >= XW'(CAPACITY)) begin
        f_rd_en = f_rd_en && (teq_pkg::kind_t'(kind) == teq_pkg::KIND_GET);
        b_rd_en = b_rd_en && (teq_pkg::kind_t'(kind) == teq_pkg::KIND_GET);
      end
    end
  end

  // Updates in the execute cycle.
  logic eq;
  assign eq = (f_count == b_count);
  always_comb begin
    f_ins_head = 1'b0; f_ins_tail = 1'b0; f_drop_tail = 1'b0;
    b_ins_head = 1'b0; b_ins_tail = 1'b0; b_drop_head = 1'b0;
    f_wdata = val;
    b_wdata = val;
    if (state == teq_pkg::S_EXEC && !full) begin
      unique case (teq_pkg::kind_t'(op))
        teq_pkg::KIND_FRONT: begin
          f_ins_head = 1'b1;
          if (!eq) begin
            f_drop_tail = 1'b1;
            b_ins_head  = 1'b1;
            b_wdata     = f_rdata;
          end
        end
        teq_pkg::KIND_MIDDLE: begin
          if (eq) f_ins_tail = 1'b1;
          else    b_ins_head = 1'b1;
        end
        teq_pkg::KIND_BACK: begin
          b_ins_tail = 1'b1;
          if (eq) begin
            if (b_count == '0) begin
              b_ins_tail = 1'b0;
              f_ins_tail = 1'b1;
            end else begin
              b_drop_head = 1'b1;
              f_ins_tail  = 1'b1;
              f_wdata     = b_rdata;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // The result register is loaded in the execute cycle.
  always_ff @(posedge clk) begin
    if (state == teq_pkg::S_EXEC) begin
      if (teq_pkg::kind_t'(op) == teq_pkg::KIND_GET) begin
        if (in_front) begin
          read_value <= f_rdata;
          status     <= teq_pkg::ST_OK;
        end else if (pos_ext < total) begin
          read_value <= b_rdata;
          status     <= teq_pkg::ST_OK;
        end else begin
          read_value <= '0;
          status     <= teq_pkg::ST_RANGE;
        end
      end else begin
        read_value <= '0;
        status     <= full ? teq_pkg::ST_FULL : teq_pkg::ST_OK;
      end
    end
  end

  assign out_valid = (state == teq_pkg::S_DONE);
endmodule

FILE: hw/rtl/triple_ended_queue.sv
// Triple-ended queue of up to CAPACITY signed words, split into a front
// and a back half, each a circular buffer in one synchronous memory. The
// halves are kept balanced (the front holds the extra element), so a
// middle insert is an insert at the seam, and a front or back insert moves
// at most one element across it. The memory read is issued in the cycle
// that accepts a request, the following cycle applies the update and loads
// the result register, and the result is offered from the next edge. The
// queue takes no new request until the result is taken and it is idle
// again; a result that waits holds off the input for as long as it waits.
// No clearing pass is needed after reset.
module triple_ended_queue #(
  parameter int unsigned CAPACITY = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  kind,
  input  logic signed [31:0] value,
  input  logic [9:0]  position,
  output logic        out_valid,
  input  logic        out_ready,
  output logic signed [31:0] read_value,
  output logic [1:0]  status
);
  localparam int unsigned HALF = (CAPACITY + 1) / 2;
  localparam int unsigned HW   = $clog2(HALF + 1);

  logic f_pf, f_pb, f_popb, b_pf, b_pb, b_popf;
  logic [31:0] f_wd, b_wd, f_rd, b_rd, rv;
  logic f_re, b_re;
  logic [HW-1:0] f_off, b_off, f_cnt, b_cnt;

  teq_ctrl #(.CAPACITY(CAPACITY), .HALF(HALF)) u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .kind, .value(value), .position,
    .out_valid, .out_ready, .read_value(rv), .status,
    .f_ins_head(f_pf), .f_ins_tail(f_pb), .f_drop_tail(f_popb),
    .b_ins_head(b_pf), .b_ins_tail(b_pb), .b_drop_head(b_popf),
    .f_wdata(f_wd), .b_wdata(b_wd), .f_rd_en(f_re), .b_rd_en(b_re),
    .f_rd_off(f_off), .b_rd_off(b_off), .f_rdata(f_rd), .b_rdata(b_rd),
    .f_count(f_cnt), .b_count(b_cnt)
  );
  assign read_value = rv;

  // Front half: an insert at the head with a simultaneous removal at the
  // tail keeps its count.
  logic [HW-1:0] f_cnt_raw;
  teq_ring #(.DEPTH(HALF)) u_front (
    .clk, .rst,
    .ins_head(f_pf), .ins_tail(f_pb),
    .drop_head(1'b0), .drop_tail(f_popb),
    .wdata(f_wd), .rd_en(f_re), .rd_off(f_off), .rdata(f_rd),
    .count(f_cnt_raw)
  );
  assign f_cnt = f_cnt_raw;

  logic [HW-1:0] b_cnt_raw;
  teq_ring #(.DEPTH(HALF)) u_back (
    .clk, .rst,
    .ins_head(b_pf), .ins_tail(b_pb),
    .drop_head(b_popf), .drop_tail(1'b0),
    .wdata(b_wd), .rd_en(b_re), .rd_off(b_off), .rdata(b_rd),
    .count(b_cnt_raw)
  );
  assign b_cnt = b_cnt_raw;
endmodule

FILE: hw/rtl/teq_checker.sv
module teq_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] status
);
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("request taken while result pending");
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status == teq_pkg::ST_OK || status == teq_pkg::ST_RANGE ||
                   status == teq_pkg::ST_FULL))
    else $error("bad status");
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !out_valid ##1 out_valid)
    else $error("result timing");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status))
    else $error("result dropped");
endmodule

bind triple_ended_queue teq_checker u_teq_checker (
  .clk, .rst, .in_valid, .in_ready, .out_valid, .out_ready, .status
);

FILE: sim/teq_checker.sv
`timescale 1ns / 100ps

module teq_scoreboard #(
  parameter int unsigned CAPACITY = 1024
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [1:0]         kind,
  input  logic signed [31:0] value,
  input  logic [9:0]         position,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [31:0] read_value,
  input  logic [1:0]         status,
  output int                 fail_count,
  output int                 pending,
  output int                 held
);

  typedef struct packed {
    logic signed [31:0] word;
    teq_pkg::status_t   st;
  } teq_result_t;

  logic signed [31:0] seq_words[$];
  teq_result_t        awaited[$];

  function automatic teq_result_t apply_request(teq_pkg::kind_t k,
                                                logic signed [31:0] w,
                                                logic [9:0] pos);
    teq_result_t r;
    int          at;
    r.word = '0;
    r.st   = teq_pkg::ST_OK;
    if (k == teq_pkg::KIND_GET) begin
      if (pos < seq_words.size()) r.word = seq_words[pos];
      else r.st = teq_pkg::ST_RANGE;
    end else if (seq_words.size() >= CAPACITY) begin
      r.st = teq_pkg::ST_FULL;
    end else begin
      case (k)
        teq_pkg::KIND_FRONT:  at = 0;
        teq_pkg::KIND_MIDDLE: at = (seq_words.size() + 1) / 2;
        default:              at = seq_words.size();
      endcase
      seq_words.insert(at, w);
    end
    return r;
  endfunction

  always @(posedge clk) begin
    teq_result_t e;
    if (rst) begin
      seq_words.delete();
      awaited.delete();
      fail_count = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (awaited.size() == 0) begin
          $error("result with nothing outstanding: read_value %0d status %0d",
                 read_value, status);
          fail_count++;
        end else begin
          e = awaited[0];
          awaited.delete(0);
          if (read_value !== e.word) begin
            $error("read_value: expected %0d, actual %0d", e.word, read_value);
            fail_count++;
          end
          if (status !== e.st) begin
            $error("status: expected %0d, actual %0d", e.st, status);
            fail_count++;
          end
        end
      end
      if (in_valid && in_ready)
        awaited.insert(awaited.size(),
                       apply_request(teq_pkg::kind_t'(kind), value, position));
    end
    pending = awaited.size();
    held    = seq_words.size();
  end

endmodule

FILE: sim/tb_triple_ended_queue.sv
`timescale 1ns / 100ps

module tb_triple_ended_queue;

  localparam int unsigned CAPACITY = 1024;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  logic [1:0]         kind;
  logic signed [31:0] value;
  logic [9:0]         position;
  logic               out_valid;
  logic               out_ready;
  logic signed [31:0] read_value;
  logic [1:0]         status;
  int                 fail_count;
  int                 pending;
  int                 held;
  bit                 calm;
  bit                 hold_off;

  triple_ended_queue #(.CAPACITY(CAPACITY)) dut (.*);

  teq_scoreboard #(.CAPACITY(CAPACITY)) checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("triple_ended_queue test failed");
    $finish;
  end

  // Sends one request, with an optional random gap first. Valid is left
  // high afterwards; the next request replaces it, release_input takes it down.
  task automatic send_request(teq_pkg::kind_t k, logic signed [31:0] w,
                              logic [9:0] pos);
    int gap;
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      gap = $urandom_range(1, 13);
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    kind     <= k;
    value    <= w;
    position <= pos;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic release_input();
    in_valid <= 1'b0;
  endtask

  function automatic logic [9:0] pick_position();
    int n;
    n = held;
    if (n == 0 || $urandom_range(0, 7) == 0) return 10'($urandom);
    case ($urandom_range(0, 3))
      0: return 10'(n - 1);
      1: return 10'(n);
      default: return 10'($urandom_range(0, n - 1));
    endcase
  endfunction

  task automatic random_request();
    teq_pkg::kind_t k;
    k = teq_pkg::kind_t'($urandom_range(0, 3));
    send_request(k, $urandom, pick_position());
  endtask

  // Receiver: random stall bursts, and one long hold-off on request.
  initial begin
    int stall;
    bit hold_done;
    hold_done = 1'b0;
    out_ready = 1'b0;
    @(negedge clk);
    forever begin
      if (hold_off && !hold_done) begin
        out_ready <= 1'b0;
        repeat (300) @(negedge clk);
        hold_done = 1'b1;
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        stall = $urandom_range(1, 13);
        repeat (stall) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
        @(negedge clk);
      end
    end
  end

  initial begin
    int guard;
    calm     = 1'b0;
    hold_off = 1'b0;
    rst      = 1'b1;
    in_valid = 1'b0;
    kind     = teq_pkg::KIND_GET;
    value    = '0;
    position = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: empty gets, each push kind, extremes, reads at the edges.
    send_request(teq_pkg::KIND_GET, 32'sd0, 10'd0);
    send_request(teq_pkg::KIND_GET, 32'sd0, 10'd1023);
    send_request(teq_pkg::KIND_FRONT, 32'h7fffffff, 10'd1023);
    send_request(teq_pkg::KIND_BACK, 32'h80000000, 10'd0);
    send_request(teq_pkg::KIND_MIDDLE, 32'hffffffff, 10'd0);
    send_request(teq_pkg::KIND_MIDDLE, 32'h00000000, 10'd0);
    send_request(teq_pkg::KIND_FRONT, 32'h55555555, 10'd0);
    send_request(teq_pkg::KIND_BACK, 32'haaaaaaaa, 10'd0);
    for (int p = 0; p < 8; p++)
      send_request(teq_pkg::KIND_GET, 32'hffffffff, 10'(p));
    send_request(teq_pkg::KIND_GET, 32'sd0, 10'd1023);

    // Long hold-off while offering requests so the input stalls.
    hold_off = 1'b1;
    for (int i = 0; i < 30; i++) random_request();
    release_input();
    while (pending != 0) @(negedge clk);

    // Fill to capacity with pushes, then send pushes and gets to a full store.
    for (int i = 0; held < CAPACITY; i++)
      send_request(teq_pkg::kind_t'($urandom_range(0, 2)), $urandom,
                   10'($urandom));
    for (int i = 0; i < 12; i++) random_request();
    send_request(teq_pkg::KIND_GET, 32'sd0, 10'd1023);
    send_request(teq_pkg::KIND_GET, 32'sd0, 10'd0);
    release_input();
    while (pending != 0) @(negedge clk);

    // Nothing can be removed, so the rest of the run is refused pushes
    // and gets on a full store, with reads at random depths.
    for (int i = 0; i < 60; i++) random_request();
    calm = 1'b1;
    for (int i = 0; i < 30; i++) random_request();
    release_input();

    guard = 0;
    while (pending != 0 && guard < 10000) begin
      @(negedge clk);
      guard++;
    end
    repeat (10) @(negedge clk);
    if (pending != 0) begin
      $display("triple_ended_queue test failed");
    end else if (fail_count == 0) begin
      $display("triple_ended_queue test passed");
    end else begin
      $display("triple_ended_queue test failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/teq_pkg.sv
hw/rtl/teq_ring.sv
hw/rtl/teq_ctrl.sv
hw/rtl/triple_ended_queue.sv
hw/rtl/teq_checker.sv
sim/teq_checker.sv
sim/tb_triple_ended_queue.sv
